// ===== rtl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg: shared definitions of the four prime sum splitter
// Sizes of the sieve stores, field widths and the result status codes.
// ----------------------------------------------------------------------------
package fps_pkg;

  // Sieve range and prime list size.
  localparam int LIMIT       = 65536;
  localparam int PRIME_SLOTS = 6542;

  // Field and address widths.
  localparam int QUERY_W = 24;
  localparam int PRIME_W = 16;
  localparam int STAT_W  = 2;
  localparam int MAP_AW  = $clog2(LIMIT);
  localparam int LIST_AW = $clog2(PRIME_SLOTS);
  localparam int CNT_W   = $clog2(PRIME_SLOTS + 1);
  // The smallest prime factor of a composite below LIMIT is at most its square root.
  localparam int SPF_W   = (MAP_AW + 1) / 2;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_IMPOSSIBLE = 2'd1,
    ST_RANGE      = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_e;

endpackage

// ===== rtl/fps_if.sv =====
// ----------------------------------------------------------------------------
// fps_if: valid/ready channels of the four prime sum splitter
// One interface for query items and one for result items.
// ----------------------------------------------------------------------------
interface fps_in_if
  import fps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [QUERY_W-1:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink   (input valid, input query_value, output ready);
endinterface

interface fps_out_if
  import fps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [PRIME_W-1:0] prime_one;
  logic [PRIME_W-1:0] prime_two;
  logic [PRIME_W-1:0] prime_three;
  logic [PRIME_W-1:0] prime_four;

  modport source (output valid, output status, output prime_one, output prime_two,
                  output prime_three, output prime_four, input ready);
  modport sink   (input valid, input status, input prime_one, input prime_two,
                  input prime_three, input prime_four, output ready);
endinterface

// ===== rtl/four_prime_sum_splitter.sv =====
// ----------------------------------------------------------------------------
// four_prime_sum_splitter: splits a query number into a sum of four primes
// A linear sieve, built on the first query, fills a smallest-prime-factor
// memory and an ascending prime list; each query then searches the list.
// ----------------------------------------------------------------------------
//
//   channel    direction  payload
//   in_ch_i    sink       query_value
//   out_ch_o   source     status, prime_one .. prime_four
//
// The first item after reset fills the factor memory and then runs the sieve,
// which reads each candidate from the factor memory and then steps along the
// prime list through its single read port, striking out candidate times prime.
// A query item tries the listed primes in ascending order, reading each from
// the prime list and then its partner from the factor memory; the small fixed
// cases and the range checks skip the search.
// Reset clears the control state only; the memories are not cleared.
// The block takes a new item while a result waits in the output register, and
// holds its finished result until the output register is free.
// ----------------------------------------------------------------------------
module four_prime_sum_splitter
  import fps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  fps_in_if.sink           in_ch_i,
  fps_out_if.source        out_ch_o
);

  typedef enum logic [12:0] {
    IDLE    = 13'b0000000000001,
    FILL    = 13'b0000000000010,
    S_MAP   = 13'b0000000000100,
    S_MAPW  = 13'b0000000001000,
    S_RD    = 13'b0000000010000,
    S_RDW   = 13'b0000000100000,
    S_CHK   = 13'b0000001000000,
    Q_START = 13'b0000010000000,
    Q_RD    = 13'b0000100000000,
    Q_RDW   = 13'b0001000000000,
    Q_MAP   = 13'b0010000000000,
    PUT     = 13'b0100000000000,
    S_NEXT  = 13'b1000000000000
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [PRIME_W-1:0] p1;
    logic [PRIME_W-1:0] p2;
    logic [PRIME_W-1:0] p3;
    logic [PRIME_W-1:0] p4;
  } res_t;

  localparam logic [MAP_AW-1:0] LAST_IDX = MAP_AW'(LIMIT - 1);

  state_e               state_q, state_d;
  logic                 built_q, built_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     j_q, j_d;
  logic [MAP_AW-1:0]    ic_q, ic_d;
  logic [QUERY_W-1:0]   n_q, n_d;
  logic [PRIME_W-1:0]   r_q, r_d;
  logic [PRIME_W-1:0]   lpf_q, lpf_d;
  logic [PRIME_W-1:0]   p_q, p_d;
  logic [MAP_AW-1:0]    qa_q, qa_d;
  logic [2*PRIME_W-1:0] prod_q, prod_d;
  res_t                 res_q, res_d;
  res_t                 out_q;
  logic                 out_valid_q;
  logic                 out_load;

  // Factor memory: zero marks a number not struck out, else its smallest prime.
  logic [SPF_W-1:0]   map_mem [LIMIT];
  logic               map_we;
  logic [MAP_AW-1:0]  map_wa, map_ra;
  logic [SPF_W-1:0]   map_wd, map_rd_q;

  // Prime list memory.
  logic [PRIME_W-1:0] list_mem [PRIME_SLOTS];
  logic               list_we;
  logic [LIST_AW-1:0] list_wa, list_ra;
  logic [PRIME_W-1:0] list_wd, list_rd_q;

  logic [PRIME_W-1:0] diff;
  assign diff = r_q - list_rd_q;

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    list_rd_q <= list_mem[list_ra];
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    built_d  = built_q;
    count_d  = count_q;
    j_d      = j_q;
    ic_d     = ic_q;
    n_d      = n_q;
    r_d      = r_q;
    lpf_d    = lpf_q;
    p_d      = p_q;
    qa_d     = qa_q;
    prod_d   = prod_q;
    res_d    = res_q;
    map_we   = 1'b0;
    map_wa   = ic_q;
    map_wd   = '0;
    map_ra   = ic_q;
    list_we  = 1'b0;
    list_wa  = count_q[LIST_AW-1:0];
    list_wd  = ic_q;
    list_ra  = j_q[LIST_AW-1:0];
    out_load = 1'b0;
    in_ch_i.ready = 1'b0;

    case (state_q)
      IDLE: begin
        in_ch_i.ready = 1'b1;
        if (in_ch_i.valid) begin
          n_d = in_ch_i.query_value;
          if (built_q) begin
            state_d = Q_START;
          end else begin
            ic_d    = '0;
            state_d = FILL;
          end
        end
      end

      // Mark every number as not struck out.
      FILL: begin
        map_we = 1'b1;
        if (ic_q == LAST_IDX) begin
          ic_d    = MAP_AW'(2);
          count_d = '0;
          state_d = S_MAP;
        end else begin
          ic_d = ic_q + 1'b1;
        end
      end

      S_MAP: begin
        state_d = S_MAPW;
      end

      // A candidate that was never struck out is prime and joins the list.
      S_MAPW: begin
        if (map_rd_q == '0) begin
          lpf_d = ic_q;
          if (count_q < CNT_W'(PRIME_SLOTS)) begin
            list_we = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else begin
          lpf_d = PRIME_W'(map_rd_q);
        end
        j_d     = '0;
        state_d = S_RD;
      end

      S_RD: begin
        if (j_q >= count_q) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_RDW;
        end
      end

      S_RDW: begin
        prod_d  = ic_q * list_rd_q;
        p_d     = list_rd_q;
        state_d = S_CHK;
      end

      // Strike out candidate times prime; stop at the smallest factor or past the sieve range.
      S_CHK: begin
        if (prod_q >= (2*PRIME_W)'(LIMIT)) begin
          state_d = S_NEXT;
        end else begin
          map_we = 1'b1;
          map_wa = prod_q[MAP_AW-1:0];
          map_wd = p_q[SPF_W-1:0];
          if (p_q == lpf_q) begin
            state_d = S_NEXT;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_RD;
          end
        end
      end

      S_NEXT: begin
        if (ic_q == LAST_IDX) begin
          built_d = 1'b1;
          state_d = Q_START;
        end else begin
          ic_d    = ic_q + 1'b1;
          state_d = S_MAP;
        end
      end

      // Fixed answers and range checks, else start the pair search.
      Q_START: begin
        res_d   = '{status: ST_OK, p1: '0, p2: '0, p3: '0, p4: '0};
        state_d = PUT;
        case (n_q)
          24'd8:   res_d = '{status: ST_OK, p1: 16'd2, p2: 16'd2, p3: 16'd2, p4: 16'd2};
          24'd9:   res_d = '{status: ST_OK, p1: 16'd2, p2: 16'd2, p3: 16'd2, p4: 16'd3};
          24'd10:  res_d = '{status: ST_OK, p1: 16'd2, p2: 16'd2, p3: 16'd3, p4: 16'd3};
          24'd11:  res_d = '{status: ST_OK, p1: 16'd2, p2: 16'd3, p3: 16'd3, p4: 16'd3};
          24'd12:  res_d = '{status: ST_OK, p1: 16'd3, p2: 16'd3, p3: 16'd3, p4: 16'd3};
          default: begin
            if (n_q < 24'd8) begin
              res_d.status = ST_IMPOSSIBLE;
            end else if (n_q >= QUERY_W'(LIMIT)) begin
              res_d.status = ST_RANGE;
            end else begin
              r_d     = n_q[0] ? PRIME_W'(n_q - 24'd5) : PRIME_W'(n_q - 24'd4);
              j_d     = '0;
              state_d = Q_RD;
            end
          end
        endcase
      end

      Q_RD: begin
        if (j_q >= count_q) begin
          res_d.status = ST_NOT_FOUND;
          state_d      = PUT;
        end else begin
          state_d = Q_RDW;
        end
      end

      Q_RDW: begin
        if (list_rd_q > r_q) begin
          res_d.status = ST_NOT_FOUND;
          state_d      = PUT;
        end else begin
          map_ra  = diff;
          qa_d    = diff;
          p_d     = list_rd_q;
          state_d = Q_MAP;
        end
      end

      // The partner is prime if it is two or more and was never struck out.
      Q_MAP: begin
        if (map_rd_q == '0 && qa_q >= MAP_AW'(2)) begin
          res_d   = '{status: ST_OK, p1: 16'd2, p2: (n_q[0] ? 16'd3 : 16'd2),
                      p3: p_q, p4: qa_q};
          state_d = PUT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = Q_RD;
        end
      end

      PUT: begin
        out_load = !out_valid_q || out_ch_o.ready;
        if (out_load) begin
          state_d = IDLE;
        end
      end

      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      built_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    ic_q   <= ic_d;
    n_q    <= n_d;
    r_q    <= r_d;
    lpf_q  <= lpf_d;
    p_q    <= p_d;
    qa_q   <= qa_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Output channel.
  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.status      = out_q.status;
  assign out_ch_o.prime_one   = out_q.p1;
  assign out_ch_o.prime_two   = out_q.p2;
  assign out_ch_o.prime_three = out_q.p3;
  assign out_ch_o.prime_four  = out_q.p4;

`ifndef SYNTHESIS
  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state is not one-hot");

  // The prime list never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(PRIME_SLOTS)) else $error("prime count exceeds the list size");

  // A result is only loaded into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ch_o.ready))
    else $error("pending result overwritten");

  // A successful result sums to the query number.
  a_sum_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_q.status == ST_OK) |=>
      (18'(out_q.p1) + 18'(out_q.p2) + 18'(out_q.p3) + 18'(out_q.p4))
        == $past(n_q[17:0]))
    else $error("four primes do not sum to the query");

  // Strike-out writes stay inside the sieve range.
  a_strike_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && map_we) |-> prod_q < (2*PRIME_W)'(LIMIT))
    else $error("strike-out address beyond the sieve range");
`endif

endmodule
